[hw/rtl/tlb_page_table_address_translator_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the address translator
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_ADDRESS_TRANSLATOR_TOP_DEFINES_SVH
`define TLB_PAGE_TABLE_ADDRESS_TRANSLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define TPAT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPAT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/tpat_pkg.sv]
// ----------------------------------------------------------------------------
// tpat_pkg
// Sizes and constants of the TLB and page table address translator.
// ----------------------------------------------------------------------------
package tpat_pkg;

   localparam int TLB_ENTRIES = 16;
   localparam int PAGE_COUNT  = 256;

   localparam int ADDR_W   = 16;
   localparam int PAGE_W   = 8;
   localparam int OFFSET_W = 8;
   localparam int FRAME_W  = 8;
   localparam int COUNT_W  = 32;

   localparam int MAP_DEPTH = 1 << PAGE_W;
   localparam int FILL_W    = $clog2(TLB_ENTRIES + 1);
   localparam int FREE_W    = $clog2(PAGE_COUNT + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

[hw/rtl/tpat_req_if.sv]
// ----------------------------------------------------------------------------
// tpat_req_if
// Request channel: one logical address per transfer.
// ----------------------------------------------------------------------------
interface tpat_req_if;
   logic                        valid;
   logic                        ready;
   logic [tpat_pkg::ADDR_W-1:0] logical_address;

   modport source (output valid, output logical_address, input ready);
   modport sink   (input valid, input logical_address, output ready);
endinterface

[hw/rtl/tpat_rsp_if.sv]
// ----------------------------------------------------------------------------
// tpat_rsp_if
// Response channel: translated address, flags and running totals.
// ----------------------------------------------------------------------------
interface tpat_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tpat_pkg::ADDR_W-1:0]  physical_address;
   logic                         tlb_hit;
   logic                         page_fault;
   logic [tpat_pkg::COUNT_W-1:0] access_total;
   logic [tpat_pkg::COUNT_W-1:0] hit_total;
   logic [tpat_pkg::COUNT_W-1:0] fault_total;

   modport source (output valid, output physical_address, output tlb_hit,
                   output page_fault, output access_total, output hit_total,
                   output fault_total, input ready);
   modport sink   (input valid, input physical_address, input tlb_hit,
                   input page_fault, input access_total, input hit_total,
                   input fault_total, output ready);
endinterface

[hw/rtl/tlb_page_table_address_translator_top.sv]
// The request page is registered, then the parallel TLB compare and the page
//   table RAM read resolve in the lookup state; the result is registered once
//   any earlier result is taken. No new address is taken until then.
// Reset: synchronous; clears the page valid bits, TLB fill count, free frame
//   pointer, counters and the response valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
// tlb_page_table_address_translator_top
// FIFO TLB in front of a demand-paged page table held in a RAM.
// ----------------------------------------------------------------------------
`include "tlb_page_table_address_translator_top_defines.svh"

module tlb_page_table_address_translator_top (
   input logic      clock,
   input logic      reset,
   tpat_req_if.sink   req_chan,
   tpat_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   localparam int N = tpat_pkg::TLB_ENTRIES;

   function automatic logic [tpat_pkg::COUNT_W-1:0] sat_inc(
      input logic [tpat_pkg::COUNT_W-1:0] v);
      return (v == tpat_pkg::COUNT_MAX) ? v : v + 1'b1;
   endfunction

   state_type state_ff, state_in;

   logic [tpat_pkg::PAGE_W-1:0]   page_ff, page_in;
   logic [tpat_pkg::OFFSET_W-1:0] offset_ff, offset_in;

   logic [tpat_pkg::PAGE_W-1:0]  tlb_page_ff  [N];
   logic [tpat_pkg::FRAME_W-1:0] tlb_frame_ff [N];
   logic [tpat_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [tpat_pkg::FREE_W-1:0]  free_ff, free_in;
   logic [tpat_pkg::MAP_DEPTH-1:0] map_valid_ff, map_valid_in;

   logic [tpat_pkg::COUNT_W-1:0] access_ff, access_in;
   logic [tpat_pkg::COUNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [tpat_pkg::COUNT_W-1:0] fault_cnt_ff, fault_cnt_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tpat_pkg::ADDR_W-1:0]  phys_ff, phys_in;
   logic                         hit_out_ff, hit_out_in;
   logic                         fault_out_ff, fault_out_in;

   logic [tpat_pkg::PAGE_W-1:0]  ram_rd_addr;
   logic [tpat_pkg::FRAME_W-1:0] ram_rd_data;
   logic [tpat_pkg::FREE_W-1:0]  free_sel;
   logic [tpat_pkg::FRAME_W-1:0] alloc_frame;
   logic [tpat_pkg::FRAME_W-1:0] tlb_hit_frame;
   logic [tpat_pkg::FRAME_W-1:0] frame;
   logic                         tlb_match;
   logic                         fault;
   logic                         done;

   // hold the read address while the result waits, so the RAM output stays put
   assign ram_rd_addr = (state_ff == ST_IDLE)
                        ? req_chan.logical_address[tpat_pkg::ADDR_W-1:tpat_pkg::OFFSET_W]
                        : page_ff;

   tpat_ram #(
      .WIDTH (tpat_pkg::FRAME_W),
      .DEPTH (tpat_pkg::MAP_DEPTH)
   ) u_map_frame (
      .clock   (clock),
      .wr_en   (done && fault),
      .wr_addr (page_ff),
      .wr_data (alloc_frame),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // parallel TLB search; the highest live match wins
   always_comb begin
      tlb_match     = 1'b0;
      tlb_hit_frame = '0;
      for (int i = 0; i < N; i++) begin
         if ((tpat_pkg::FILL_W'(i) < fill_ff) && (tlb_page_ff[i] == page_ff)) begin
            tlb_match     = 1'b1;
            tlb_hit_frame = tlb_frame_ff[i];
         end
      end
   end

   assign free_sel    = (free_ff >= tpat_pkg::FREE_W'(tpat_pkg::PAGE_COUNT)) ? '0 : free_ff;
   assign alloc_frame = free_sel[tpat_pkg::FRAME_W-1:0];
   assign fault       = !tlb_match && !map_valid_ff[page_ff];
   assign frame       = tlb_match ? tlb_hit_frame : (fault ? alloc_frame : ram_rd_data);
   assign done        = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      offset_in    = offset_ff;
      fill_in      = fill_ff;
      free_in      = free_ff;
      map_valid_in = map_valid_ff;
      access_in    = access_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      phys_in      = phys_ff;
      hit_out_in   = hit_out_ff;
      fault_out_in = fault_out_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               page_in   = req_chan.logical_address[tpat_pkg::ADDR_W-1:tpat_pkg::OFFSET_W];
               offset_in = req_chan.logical_address[tpat_pkg::OFFSET_W-1:0];
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (done) begin
               access_in = sat_inc(access_ff);
               if (tlb_match) begin
                  hit_cnt_in = sat_inc(hit_cnt_ff);
               end
               if (fault) begin
                  fault_cnt_in          = sat_inc(fault_cnt_ff);
                  free_in               = free_sel + 1'b1;
                  map_valid_in[page_ff] = 1'b1;
                  fill_in = (fill_ff >= tpat_pkg::FILL_W'(N))
                            ? tpat_pkg::FILL_W'(N) : fill_ff + 1'b1;
               end
               rsp_valid_in = 1'b1;
               phys_in      = {frame, offset_ff};
               hit_out_in   = tlb_match;
               fault_out_in = fault;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         free_ff      <= '0;
         map_valid_ff <= '0;
         access_ff    <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         free_ff      <= free_in;
         map_valid_ff <= map_valid_in;
         access_ff    <= access_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and TLB contents; the TLB shifts toward the back on insert
   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      offset_ff    <= offset_in;
      phys_ff      <= phys_in;
      hit_out_ff   <= hit_out_in;
      fault_out_ff <= fault_out_in;
      if (done && fault) begin
         for (int i = N - 1; i > 0; i--) begin
            tlb_page_ff[i]  <= tlb_page_ff[i-1];
            tlb_frame_ff[i] <= tlb_frame_ff[i-1];
         end
         tlb_page_ff[0]  <= page_ff;
         tlb_frame_ff[0] <= alloc_frame;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.physical_address = phys_ff;
   assign rsp_chan.tlb_hit          = hit_out_ff;
   assign rsp_chan.page_fault       = fault_out_ff;
   assign rsp_chan.access_total     = access_ff;
   assign rsp_chan.hit_total        = hit_cnt_ff;
   assign rsp_chan.fault_total      = fault_cnt_ff;

   `TPAT_ASSERT_IMP(a_fill_bound, 1'b1, fill_ff <= tpat_pkg::FILL_W'(N), "TLB fill above depth")
   `TPAT_ASSERT_IMP(a_hit_xor_fault, rsp_valid_ff, !(hit_out_ff && fault_out_ff), "hit with fault")
   `TPAT_ASSERT_NXT(a_fault_maps, done && fault, map_valid_ff[$past(page_ff)], "fault not mapped")
   `TPAT_ASSERT_NXT(a_access_inc, done && !(&access_ff), access_ff != $past(access_ff), "stuck")
   `TPAT_ASSERT_NXT(a_fault_front, done && fault, tlb_page_ff[0] == $past(page_ff), "not in front")

endmodule

[hw/rtl/tpat_ram.sv]
// ----------------------------------------------------------------------------
// tpat_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tpat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[verif/tlb_page_table_address_translator_top_tb.sv]
// ----------------------------------------------------------------------------
// tlb_page_table_address_translator_top_tb
// Drives logical addresses into the translator and checks every translated
// address, hit and fault flag and running total. The checks come from a typed
// directed table first, then from random address streams built around the
// live TLB working set. Idle patterns on both channels change between phases.
// ----------------------------------------------------------------------------
module tlb_page_table_address_translator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PER_PHASE = 680;
   localparam int RECV_HOLD_CYCLES = 120;
   localparam int DRAIN_LIMIT      = 20000;

   typedef struct packed {
      logic [tpat_pkg::ADDR_W-1:0]  physical_address;
      logic                         tlb_hit;
      logic                         page_fault;
      logic [tpat_pkg::COUNT_W-1:0] access_total;
      logic [tpat_pkg::COUNT_W-1:0] hit_total;
      logic [tpat_pkg::COUNT_W-1:0] fault_total;
   } xlat_type;

   typedef struct packed {
      logic [tpat_pkg::ADDR_W-1:0] addr;
      logic                        typed;
      xlat_type                    want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpat_req_if req_if ();
   tpat_rsp_if rsp_if ();

   tlb_page_table_address_translator_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // translation state mirrored from the block
   bit                           page_mapped [tpat_pkg::MAP_DEPTH];
   logic [tpat_pkg::FRAME_W-1:0] page_frame  [tpat_pkg::MAP_DEPTH];
   logic [tpat_pkg::PAGE_W-1:0]  tlb_pg      [tpat_pkg::TLB_ENTRIES];
   logic [tpat_pkg::FRAME_W-1:0] tlb_fr      [tpat_pkg::TLB_ENTRIES];
   int                           tlb_live   = 0;
   int                           next_frame = 0;
   logic [tpat_pkg::COUNT_W-1:0] n_access   = '0;
   logic [tpat_pkg::COUNT_W-1:0] n_hit      = '0;
   logic [tpat_pkg::COUNT_W-1:0] n_fault    = '0;

   xlat_type    expected_xlat_q [$];
   dir_row_type row_check_q     [$];
   dir_row_type dir_table       [$];

   // stimulus bookkeeping
   bit                          issued [tpat_pkg::MAP_DEPTH];
   logic [tpat_pkg::PAGE_W-1:0] issued_list  [$];
   logic [tpat_pkg::PAGE_W-1:0] recent_pages [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          phase         = 0;
   bit          hold_done     = 1'b0;
   int          hold_left     = 0;
   int          fail_count    = 0;

   function automatic logic [tpat_pkg::COUNT_W-1:0] sat_inc(
      input logic [tpat_pkg::COUNT_W-1:0] v);
      return (v == tpat_pkg::COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic xlat_type predict_translation(input logic [tpat_pkg::ADDR_W-1:0] la);
      xlat_type                     res;
      logic [tpat_pkg::PAGE_W-1:0]  pg;
      logic [tpat_pkg::FRAME_W-1:0] frame;
      bit                           found;
      bit                           faulted;
      int                           i;
      pg      = la[tpat_pkg::ADDR_W-1:tpat_pkg::OFFSET_W];
      frame   = '0;
      found   = 1'b0;
      faulted = 1'b0;
      n_access = sat_inc(n_access);
      // later entries win, as in the parallel compare
      for (i = 0; i < tlb_live && i < tpat_pkg::TLB_ENTRIES; i++) begin
         if (tlb_pg[i] == pg) begin
            found = 1'b1;
            frame = tlb_fr[i];
         end
      end
      if (found) begin
         n_hit = sat_inc(n_hit);
      end else if (!page_mapped[pg]) begin
         faulted = 1'b1;
         if (next_frame >= tpat_pkg::PAGE_COUNT) next_frame = 0;
         frame = tpat_pkg::FRAME_W'(next_frame);
         page_mapped[pg] = 1'b1;
         page_frame[pg]  = frame;
         next_frame++;
         n_fault = sat_inc(n_fault);
         // shift the FIFO, dropping the oldest entry when full
         if (tlb_live >= tpat_pkg::TLB_ENTRIES) tlb_live = tpat_pkg::TLB_ENTRIES - 1;
         for (i = tlb_live; i > 0; i--) begin
            tlb_pg[i] = tlb_pg[i-1];
            tlb_fr[i] = tlb_fr[i-1];
         end
         tlb_live++;
         tlb_pg[0] = pg;
         tlb_fr[0] = frame;
      end else begin
         frame = page_frame[pg];
      end
      res.physical_address = {frame, la[tpat_pkg::OFFSET_W-1:0]};
      res.tlb_hit          = found;
      res.page_fault       = faulted;
      res.access_total     = n_access;
      res.hit_total        = n_hit;
      res.fault_total      = n_fault;
      return res;
   endfunction

   function automatic dir_row_type dir_row(input logic [tpat_pkg::ADDR_W-1:0] a,
                                           input bit typed,
                                           input logic [tpat_pkg::ADDR_W-1:0] pa,
                                           input bit h, input bit f, input int acc,
                                           input int hits, input int faults);
      dir_row_type r;
      r.addr                  = a;
      r.typed                 = typed;
      r.want.physical_address = pa;
      r.want.tlb_hit          = h;
      r.want.page_fault       = f;
      r.want.access_total     = tpat_pkg::COUNT_W'(acc);
      r.want.hit_total        = tpat_pkg::COUNT_W'(hits);
      r.want.fault_total      = tpat_pkg::COUNT_W'(faults);
      return r;
   endfunction

   task automatic log_failure(input string what, input xlat_type want, input xlat_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected pa=%h hit=%b fault=%b acc=%0d hits=%0d faults=%0d",
                  $time, what, want.physical_address, want.tlb_hit, want.page_fault,
                  want.access_total, want.hit_total, want.fault_total,
                  "\n      actual   pa=%h hit=%b fault=%b acc=%0d hits=%0d faults=%0d",
                  got.physical_address, got.tlb_hit, got.page_fault,
                  got.access_total, got.hit_total, got.fault_total);
   endtask

   // issue one address and hold it until the transfer
   task automatic issue(input dir_row_type r);
      logic [tpat_pkg::PAGE_W-1:0] pg;
      pg = r.addr[tpat_pkg::ADDR_W-1:tpat_pkg::OFFSET_W];
      if (!issued[pg]) begin
         issued[pg] = 1'b1;
         issued_list.push_back(pg);
         recent_pages.push_front(pg);
         if (recent_pages.size() > tpat_pkg::TLB_ENTRIES) void'(recent_pages.pop_back());
      end
      row_check_q.push_back(r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.logical_address <= r.addr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_xlat_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stalls plus one long hold-off at the start of the last phase
   initial begin : receiver
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (phase == 2 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = RECV_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : req_monitor
      dir_row_type info;
      xlat_type    model;
      if (!reset && req_if.valid && req_if.ready) begin
         info  = row_check_q.pop_front();
         model = predict_translation(req_if.logical_address);
         expected_xlat_q.push_back(info.typed ? info.want : model);
      end
   end

   always @(posedge clock) begin : rsp_checker
      xlat_type got;
      xlat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.physical_address = rsp_if.physical_address;
         got.tlb_hit          = rsp_if.tlb_hit;
         got.page_fault       = rsp_if.page_fault;
         got.access_total     = rsp_if.access_total;
         got.hit_total        = rsp_if.hit_total;
         got.fault_total      = rsp_if.fault_total;
         if (expected_xlat_q.size() == 0) begin
            log_failure("unexpected result", '0, got);
         end else begin
            want = expected_xlat_q.pop_front();
            if (got.physical_address !== want.physical_address ||
                got.tlb_hit          !== want.tlb_hit ||
                got.page_fault       !== want.page_fault ||
                got.access_total     !== want.access_total ||
                got.hit_total        !== want.hit_total ||
                got.fault_total      !== want.fault_total)
               log_failure("mismatch", want, got);
         end
      end
   end

   initial begin : stimulus
      int                          k;
      int                          n;
      int                          ph;
      int                          r;
      int                          start;
      logic [tpat_pkg::PAGE_W-1:0] pg;

      req_if.valid           = 1'b0;
      req_if.logical_address = '0;

      // first touches after reset, both address extremes, hits on fresh entries
      dir_table.push_back(dir_row(16'h0000, 1, 16'h0000, 0, 1, 1, 0, 1));
      dir_table.push_back(dir_row(16'h00FF, 1, 16'h00FF, 1, 0, 2, 1, 1));
      dir_table.push_back(dir_row(16'hFFFF, 1, 16'h01FF, 0, 1, 3, 1, 2));
      dir_table.push_back(dir_row(16'hFF00, 1, 16'h0100, 1, 0, 4, 2, 2));
      dir_table.push_back(dir_row(16'h0180, 1, 16'h0280, 0, 1, 5, 2, 3));
      // fill the TLB and push page 0 out of it
      for (k = 0; k < 14; k++)
         dir_table.push_back(dir_row({8'(16 + k), 8'(k * 17)}, 0, '0, 0, 0, 0, 0, 0));
      // mapped page missing from the TLB, then a surviving entry
      dir_table.push_back(dir_row(16'h0042, 0, '0, 0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(16'hFF80, 0, '0, 0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(16'h00AA, 0, '0, 0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(16'h1D55, 0, '0, 0, 0, 0, 0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase = ph;
         if (ph == 0) begin
            foreach (dir_table[i]) issue(dir_table[i]);
         end
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            r = $urandom_range(99);
            if ((r < 12 || issued_list.size() == 0) &&
                issued_list.size() < tpat_pkg::MAP_DEPTH) begin
               // first touch of a page: fault
               pg = '0;
               start = $urandom_range(tpat_pkg::MAP_DEPTH - 1);
               for (k = 0; k < tpat_pkg::MAP_DEPTH; k++) begin
                  if (!issued[(start + k) % tpat_pkg::MAP_DEPTH]) begin
                     pg = tpat_pkg::PAGE_W'((start + k) % tpat_pkg::MAP_DEPTH);
                     break;
                  end
               end
            end else if (r < 60) begin
               pg = recent_pages[$urandom_range(recent_pages.size() - 1)];
            end else if (r < 90) begin
               pg = issued_list[$urandom_range(issued_list.size() - 1)];
            end else begin
               pg = tpat_pkg::PAGE_W'($urandom_range(tpat_pkg::MAP_DEPTH - 1));
            end
            issue(dir_row({pg, 8'($urandom_range(255))}, 0, '0, 0, 0, 0, 0, 0));
         end
         drain_results();
      end

      while (expected_xlat_q.size() != 0)
         log_failure("missing result", expected_xlat_q.pop_front(), 'x);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
